// ===== design/bps_pkg.sv =====
// Shared constants and types for the byte pattern scanner.
// Used by every module of the block except bps_ram; depends on nothing.
`default_nettype none

package bps_pkg;

	localparam int BPS_MAX_PATTERN = 128;

	// Action codes of an input beat.
	localparam logic [1:0] ACT_LOAD    = 2'd0;
	localparam logic [1:0] ACT_SCAN    = 2'd1;
	localparam logic [1:0] ACT_RESTART = 2'd2;

	// Configuration register indexes.
	localparam logic [1:0] REG_PATTERN_LENGTH = 2'd0;
	localparam logic [1:0] REG_CONTEXT_WINDOW = 2'd1;
	localparam logic [1:0] REG_REGION_BASE    = 2'd2;
	localparam logic [1:0] REG_REGION_SIZE    = 2'd3;

	// Configuration reset values.
	localparam logic [7:0]  PATTERN_LENGTH_RESET = 8'd1;
	localparam logic [11:0] CONTEXT_WINDOW_RESET = 12'd10;

	// Per-beat commands from the input stage to the window compare.
	typedef struct packed {
		logic       load;
		logic       shift;
		logic       clear;
		logic [6:0] index;
		logic [7:0] data;
	} bps_win_ctrl_t;

endpackage

`default_nettype wire

// ===== design/bps_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Self-contained; no package dependency.
`default_nettype none

module bps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== design/bps_window.sv =====
// Byte history, length-aligned pattern copy and the parallel window compare.
// Uses bps_pkg and one bps_ram instance as the pattern store.
`default_nettype none

module bps_window #(
	parameter int MAX_PATTERN = bps_pkg::BPS_MAX_PATTERN,
	localparam int LW = $clog2(MAX_PATTERN + 1),
	localparam int AW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire bps_pkg::bps_win_ctrl_t ctrl,
	input  wire logic [LW-1:0]         len,
	input  wire logic                  realign,
	output logic                       match,
	output logic                       busy
);

	import bps_pkg::*;

	localparam int XW = (LW > 7) ? LW : 7;

	typedef enum logic [2:0] {
		ST_RUN   = 3'b001,
		ST_ALIGN = 3'b010,
		ST_DRAIN = 3'b100
	} bps_align_state_t;

	bps_align_state_t state_q;
	logic [LW-1:0]    cnt_q;
	logic             rdv_q;
	logic [7:0]       rd_data;

	logic [7:0] recent_q [MAX_PATTERN];
	logic [7:0] align_q  [MAX_PATTERN];
	logic [7:0] new_win  [MAX_PATTERN];
	logic [MAX_PATTERN-1:0] lane_ok;

	logic [XW-1:0] idx_x;
	logic [XW-1:0] len_x;
	logic [XW-1:0] tgt;
	logic          load_hit;
	logic          ram_we;

	// align_q[j] holds pattern byte len-1-j, so lane j compares against the
	// byte that arrived j beats ago.
	assign idx_x    = XW'(ctrl.index);
	assign len_x    = XW'(len);
	assign load_hit = idx_x < len_x;
	assign tgt      = len_x - idx_x - XW'(1);
	assign ram_we   = ctrl.load && (32'(ctrl.index) < MAX_PATTERN);

	bps_ram #(
		.WIDTH(8),
		.DEPTH(MAX_PATTERN)
	) u_pattern_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(AW'(ctrl.index)),
		.wdata(ctrl.data),
		.raddr(AW'(cnt_q)),
		.rdata(rd_data)
	);

	always_comb begin
		for (int j = 0; j < MAX_PATTERN; j++) begin
			new_win[j] = (j == 0) ? ctrl.data : recent_q[(j > 0) ? j - 1 : 0];
			lane_ok[j] = (new_win[j] == align_q[j]) || (LW'(j) >= len);
		end
	end

	assign match = &lane_ok;
	assign busy  = (state_q != ST_RUN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < MAX_PATTERN; j++) begin
				recent_q[j] <= 8'd0;
			end
		end else if (ctrl.clear) begin
			for (int j = 0; j < MAX_PATTERN; j++) begin
				recent_q[j] <= 8'd0;
			end
		end else if (ctrl.shift) begin
			recent_q[0] <= ctrl.data;
			for (int j = 1; j < MAX_PATTERN; j++) begin
				recent_q[j] <= recent_q[j-1];
			end
		end
	end

	// After a length change the aligned copy is rebuilt by streaming the
	// pattern store in order; bytes pushed up past the new length are unused.
	always_ff @(posedge clk) begin
		if (rdv_q) begin
			align_q[0] <= rd_data;
			for (int j = 1; j < MAX_PATTERN; j++) begin
				align_q[j] <= align_q[j-1];
			end
		end else if (ctrl.load && load_hit) begin
			for (int j = 0; j < MAX_PATTERN; j++) begin
				if (XW'(j) == tgt) begin
					align_q[j] <= ctrl.data;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RUN;
			cnt_q   <= '0;
			rdv_q   <= 1'b0;
		end else begin
			rdv_q <= (state_q == ST_ALIGN);
			if (realign) begin
				state_q <= ST_ALIGN;
				cnt_q   <= '0;
			end else begin
				case (state_q)
					ST_RUN: begin
						cnt_q <= '0;
					end
					ST_ALIGN: begin
						if (cnt_q == len - LW'(1)) begin
							state_q <= ST_DRAIN;
						end else begin
							cnt_q <= cnt_q + LW'(1);
						end
					end
					ST_DRAIN: begin
						state_q <= ST_RUN;
					end
					default: begin
						state_q <= ST_RUN;
					end
				endcase
			end
		end
	end

endmodule

`default_nettype wire

// ===== design/bps_span.sv =====
// Match and context span arithmetic: offsets, clamping and address adds,
// in two stages followed by the output register. Uses bps_pkg.
`default_nettype none

module bps_span #(
	parameter int MAX_PATTERN = bps_pkg::BPS_MAX_PATTERN,
	localparam int LW = $clog2(MAX_PATTERN + 1)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          hit,
	input  wire logic [31:0]   hit_pos,
	input  wire logic [LW-1:0] hit_len,
	output logic               ready,
	input  wire logic [11:0]   context_window,
	input  wire logic [63:0]   region_base,
	input  wire logic [31:0]   region_size,
	output logic               out_valid,
	input  wire logic          out_ready,
	output logic [63:0]        match_address,
	output logic [63:0]        context_address,
	output logic [13:0]        context_length
);

	import bps_pkg::*;

	logic          v_s2;
	logic [31:0]   pos_s2;
	logic [LW-1:0] len_s2;

	logic          v_s3;
	logic [31:0]   start_s3;
	logic [31:0]   cstart_s3;
	logic [13:0]   clen_s3;

	logic          ready_s3;
	logic          ready_out;

	logic [31:0]   start;
	logic [31:0]   cstart;
	logic [32:0]   cend_raw;
	logic [31:0]   cend;

	assign ready_out = !out_valid || out_ready;
	assign ready_s3  = !v_s3 || ready_out;
	assign ready     = !v_s2 || ready_s3;

	// The scan byte is known to lie inside the region, so pos + 1 fits in
	// 32 bits and the span end never falls below its start.
	always_comb begin
		start    = pos_s2 + 32'd1 - 32'(len_s2);
		cstart   = (start > 32'(context_window)) ? start - 32'(context_window) : 32'd0;
		cend_raw = {1'b0, pos_s2} + 33'd1 + 33'(context_window);
		cend     = (cend_raw > {1'b0, region_size}) ? region_size : cend_raw[31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (ready) begin
				v_s2 <= hit;
			end
			if (ready_s3) begin
				v_s3 <= v_s2;
			end
			if (ready_out) begin
				out_valid <= v_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ready && hit) begin
			pos_s2 <= hit_pos;
			len_s2 <= hit_len;
		end
		if (ready_s3 && v_s2) begin
			start_s3  <= start;
			cstart_s3 <= cstart;
			clen_s3   <= 14'(cend - cstart);
		end
		if (ready_out && v_s3) begin
			match_address   <= region_base + 64'(start_s3);
			context_address <= region_base + 64'(cstart_s3);
			context_length  <= clen_s3;
		end
	end

endmodule

`default_nettype wire

// ===== design/byte_pattern_scanner.sv =====
// Byte pattern scanner: one beat accepted per cycle while in_ready is high; a hit
// passes the input register and the bps_span stages before it shows on out_valid.
// The rate is set by the combinational compare of the whole window in bps_window
// and by the scan state update. A pattern_length write holds in_ready low in its
// own cycle and while the aligned pattern copy is rebuilt from the store.
// Reset restores register defaults and clears history, position and holdoff.
`default_nettype none

module byte_pattern_scanner #(
	parameter int MAX_PATTERN = bps_pkg::BPS_MAX_PATTERN
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_write,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [63:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  action,
	input  wire logic [6:0]  pattern_index,
	input  wire logic [7:0]  data_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [63:0]      match_address,
	output logic [63:0]      context_address,
	output logic [13:0]      context_length
);

	import bps_pkg::*;

	localparam int LW = $clog2(MAX_PATTERN + 1);

	logic [7:0]  pattern_length_q;
	logic [11:0] context_window_q;
	logic [63:0] region_base_q;
	logic [31:0] region_size_q;

	logic [31:0] pos_q;
	logic [7:0]  holdoff_q;

	logic        v_s1;
	logic [1:0]  action_s1;
	logic [6:0]  index_s1;
	logic [7:0]  byte_s1;

	logic [LW-1:0]  act_len;
	bps_win_ctrl_t  win_ctrl;
	logic           win_match;
	logic           win_busy;
	logic           realign;
	logic           span_ready;
	logic           s1_adv;
	logic           scan_ok;
	logic           reach;
	logic           hit;

	always_comb begin
		if (pattern_length_q == 8'd0) begin
			act_len = LW'(1);
		end else if (32'(pattern_length_q) > MAX_PATTERN) begin
			act_len = LW'(MAX_PATTERN);
		end else begin
			act_len = LW'(pattern_length_q);
		end
	end

	assign realign  = cfg_write && (cfg_index == REG_PATTERN_LENGTH);
	assign in_ready = !win_busy && !realign && (!v_s1 || span_ready);
	assign s1_adv   = v_s1 && span_ready;

	assign scan_ok = (action_s1 == ACT_SCAN) && (pos_q < region_size_q);
	assign reach   = ({1'b0, pos_q} + 33'd1) >= 33'(act_len);
	assign hit     = scan_ok && (holdoff_q == 8'd0) && reach && win_match;

	always_comb begin
		win_ctrl.load  = s1_adv && (action_s1 == ACT_LOAD);
		win_ctrl.shift = s1_adv && scan_ok;
		win_ctrl.clear = s1_adv && (action_s1 == ACT_RESTART);
		win_ctrl.index = index_s1;
		win_ctrl.data  = byte_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_length_q <= PATTERN_LENGTH_RESET;
			context_window_q <= CONTEXT_WINDOW_RESET;
			region_base_q    <= 64'd0;
			region_size_q    <= 32'd0;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_PATTERN_LENGTH: pattern_length_q <= cfg_data[7:0];
				REG_CONTEXT_WINDOW: context_window_q <= cfg_data[11:0];
				REG_REGION_BASE:    region_base_q    <= cfg_data;
				REG_REGION_SIZE:    region_size_q    <= cfg_data[31:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			v_s1 <= 1'b1;
		end else if (s1_adv) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			action_s1 <= action;
			index_s1  <= pattern_index;
			byte_s1   <= data_byte;
		end
	end

	// After a hit the next act_len - 1 scan bytes may not end a match.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= 32'd0;
			holdoff_q <= 8'd0;
		end else if (win_ctrl.clear) begin
			pos_q     <= 32'd0;
			holdoff_q <= 8'd0;
		end else if (win_ctrl.shift) begin
			pos_q <= pos_q + 32'd1;
			if (holdoff_q != 8'd0) begin
				holdoff_q <= holdoff_q - 8'd1;
			end else if (hit) begin
				holdoff_q <= 8'(act_len - LW'(1));
			end
		end
	end

	bps_window #(
		.MAX_PATTERN(MAX_PATTERN)
	) u_window (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (win_ctrl),
		.len    (act_len),
		.realign(realign),
		.match  (win_match),
		.busy   (win_busy)
	);

	bps_span #(
		.MAX_PATTERN(MAX_PATTERN)
	) u_span (
		.clk            (clk),
		.arst_n         (arst_n),
		.hit            (s1_adv && hit),
		.hit_pos        (pos_q),
		.hit_len        (act_len),
		.ready          (span_ready),
		.context_window (context_window_q),
		.region_base    (region_base_q),
		.region_size    (region_size_q),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.match_address  (match_address),
		.context_address(context_address),
		.context_length (context_length)
	);

endmodule

`default_nettype wire

// ===== tb/bps_hit_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the byte pattern scanner: watches the config port and both
// channels, predicts each hit and compares it with what the block delivers.
// Depends on bps_pkg for action codes, register indexes and reset values.

module bps_hit_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_write,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [63:0] cfg_data,
	input  wire logic        in_valid,
	input  wire logic        in_ready,
	input  wire logic [1:0]  action,
	input  wire logic [6:0]  pattern_index,
	input  wire logic [7:0]  data_byte,
	input  wire logic        out_valid,
	input  wire logic        out_ready,
	input  wire logic [63:0] match_address,
	input  wire logic [63:0] context_address,
	input  wire logic [13:0] context_length,
	output int               mismatches,
	output int               hits_pending
);
	import bps_pkg::*;

	typedef struct packed {
		logic [63:0] match_address;
		logic [63:0] context_address;
		logic [13:0] context_length;
	} hit_t;

	logic [7:0]  pattern_len_reg;
	logic [11:0] window_reg;
	logic [63:0] base_reg;
	logic [31:0] size_reg;
	logic [7:0]  pattern_mem [BPS_MAX_PATTERN];
	logic [7:0]  history [BPS_MAX_PATTERN];
	logic [31:0] position;
	logic [7:0]  holdoff;
	hit_t        expected_hits [$];
	hit_t        oldest;

	function automatic int active_len();
		if (pattern_len_reg == 8'd0)
			return 1;
		if (pattern_len_reg > BPS_MAX_PATTERN)
			return BPS_MAX_PATTERN;
		return int'(pattern_len_reg);
	endfunction

	// Shifts one region byte into the history and queues the hit it ends, if any.
	function automatic void scan_byte(input logic [7:0] b);
		int          len;
		bit          same;
		logic [63:0] seen;
		logic [63:0] start;
		logic [63:0] span_start;
		logic [63:0] span_end;
		hit_t        hit;
		if (position >= size_reg)
			return;
		seen = 64'(position) + 64'd1;
		position = position + 32'd1;
		for (int i = BPS_MAX_PATTERN - 1; i > 0; i--)
			history[i] = history[i - 1];
		history[0] = b;
		if (holdoff != 8'd0) begin
			holdoff = holdoff - 8'd1;
			return;
		end
		len = active_len();
		if (seen < 64'(len))
			return;
		same = 1'b1;
		for (int i = 0; i < len; i++)
			if (history[len - 1 - i] != pattern_mem[i])
				same = 1'b0;
		if (!same)
			return;
		holdoff = 8'(len - 1);
		start = seen - 64'(len);
		span_start = (start > 64'(window_reg)) ? start - 64'(window_reg) : 64'd0;
		span_end = start + 64'(len) + 64'(window_reg);
		if (span_end > 64'(size_reg))
			span_end = 64'(size_reg);
		hit.match_address = base_reg + start;
		hit.context_address = base_reg + span_start;
		hit.context_length = 14'(span_end - span_start);
		expected_hits.push_back(hit);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_len_reg = PATTERN_LENGTH_RESET;
			window_reg = CONTEXT_WINDOW_RESET;
			base_reg = 64'd0;
			size_reg = 32'd0;
			position = 32'd0;
			holdoff = 8'd0;
			for (int i = 0; i < BPS_MAX_PATTERN; i++) begin
				history[i] = 8'd0;
				pattern_mem[i] = 8'd0;
			end
			expected_hits.delete();
			hits_pending = 0;
		end else begin
			// A hit leaves the block only after passing its pipeline registers, so the
			// output side is handled before this edge's input beat.
			if (out_valid && out_ready) begin
				if (expected_hits.size() == 0) begin
					$error("unexpected hit: match_address %h", match_address);
					mismatches++;
				end else begin
					oldest = expected_hits.pop_front();
					if (match_address !== oldest.match_address) begin
						$error("match_address: expected %h, got %h",
							oldest.match_address, match_address);
						mismatches++;
					end
					if (context_address !== oldest.context_address) begin
						$error("context_address: expected %h, got %h",
							oldest.context_address, context_address);
						mismatches++;
					end
					if (context_length !== oldest.context_length) begin
						$error("context_length: expected %0d, got %0d",
							oldest.context_length, context_length);
						mismatches++;
					end
				end
			end
			if (cfg_write) begin
				case (cfg_index)
					REG_PATTERN_LENGTH: pattern_len_reg = cfg_data[7:0];
					REG_CONTEXT_WINDOW: window_reg = cfg_data[11:0];
					REG_REGION_BASE:    base_reg = cfg_data;
					REG_REGION_SIZE:    size_reg = cfg_data[31:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				case (action)
					ACT_LOAD: pattern_mem[pattern_index] = data_byte;
					ACT_SCAN: scan_byte(data_byte);
					ACT_RESTART: begin
						position = 32'd0;
						holdoff = 8'd0;
						for (int i = 0; i < BPS_MAX_PATTERN; i++)
							history[i] = 8'd0;
					end
					default: ;
				endcase
			end
			hits_pending = expected_hits.size();
		end
	end

endmodule

// ===== tb/tb_byte_pattern_scanner.sv =====
`timescale 1ns / 100ps
// Top of the byte pattern scanner testbench: clock, reset, config writes and
// beats for both channels, plus the verdict. Needs bps_pkg, the scanner RTL
// and bps_hit_checker, which does all prediction and comparison.

module tb_byte_pattern_scanner;
	import bps_pkg::*;

	localparam logic [1:0] ACT_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 500000;
	localparam int ITEM_TARGET = 450;
	localparam int CALM_FROM = 390;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_write = 1'b0;
	logic [1:0]  cfg_index = REG_PATTERN_LENGTH;
	logic [63:0] cfg_data = 64'd0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  action = ACT_LOAD;
	logic [6:0]  pattern_index = 7'd0;
	logic [7:0]  data_byte = 8'd0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [63:0] match_address;
	logic [63:0] context_address;
	logic [13:0] context_length;
	int          mismatches;
	int          hits_pending;

	int          cycle_count = 0;
	bit          calm = 1'b0;
	int          fed_items = 0;
	logic [31:0] size_now = 32'd0;
	logic [31:0] fill = 32'd0;
	logic [7:0]  pat_shadow [BPS_MAX_PATTERN];
	bit [BPS_MAX_PATTERN-1:0] loaded = '0;
	int          eff_len = 1;
	int          insert_at = -1;
	int          break_at = -1;
	logic [7:0]  sym_a = 8'h5A;
	logic [7:0]  sym_b = 8'hC3;

	byte_pattern_scanner i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_write       (cfg_write),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.action          (action),
		.pattern_index   (pattern_index),
		.data_byte       (data_byte),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.match_address   (match_address),
		.context_address (context_address),
		.context_length  (context_length)
	);

	bps_hit_checker i_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_write       (cfg_write),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.action          (action),
		.pattern_index   (pattern_index),
		.data_byte       (data_byte),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.match_address   (match_address),
		.context_address (context_address),
		.context_length  (context_length),
		.mismatches      (mismatches),
		.hits_pending    (hits_pending)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Result side: stalls in bursts, with stretches of steady readiness between.
	initial begin
		forever begin
			@(negedge clk);
			if (!calm && $urandom_range(0, 4) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(negedge clk);
			end
			out_ready <= 1'b1;
			repeat ($urandom_range(0, 12)) @(negedge clk);
		end
	end

	function automatic logic [7:0] pick_symbol();
		case ($urandom_range(0, 9))
			0: return 8'($urandom);
			1, 2, 3, 4, 5: return sym_a;
			default: return sym_b;
		endcase
	endfunction

	// Presents one beat, possibly after an idle burst, and returns once it is taken.
	// Valid stays high afterwards so that the next beat can follow back to back.
	task automatic send_beat(input logic [1:0] a, input logic [6:0] idx,
			input logic [7:0] b);
		int gap;
		gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 19) : 0;
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		action <= a;
		pattern_index <= idx;
		data_byte <= b;
		do @(posedge clk); while (!in_ready);
		fed_items++;
		case (a)
			ACT_LOAD: begin
				pat_shadow[idx] = b;
				loaded[idx] = 1'b1;
			end
			ACT_SCAN: begin
				if (fill < size_now)
					fill++;
			end
			ACT_RESTART: begin
				fill = 32'd0;
			end
			default: ;
		endcase
	endtask

	// Drops valid and waits until every predicted hit is out and the pipe is empty.
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (hits_pending != 0) @(negedge clk);
		repeat (10) @(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [63:0] value);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_write <= 1'b0;
		if (idx == REG_REGION_SIZE)
			size_now = value[31:0];
	endtask

	// Unused upper data bits carry noise. The length goes last, since its
	// write starts the rebuild of the aligned pattern.
	task automatic configure(input logic [7:0] len, input logic [11:0] win,
			input logic [63:0] base, input logic [31:0] size_v);
		logic [63:0] junk;
		junk = {$urandom, $urandom};
		settle();
		write_reg(REG_CONTEXT_WINDOW, {junk[63:12], win});
		write_reg(REG_REGION_BASE, base);
		write_reg(REG_REGION_SIZE, {junk[63:32], size_v});
		write_reg(REG_PATTERN_LENGTH, {junk[63:8], len});
		eff_len = (len == 8'd0) ? 1 : (len > BPS_MAX_PATTERN) ? BPS_MAX_PATTERN : int'(len);
		insert_at = -1;
	endtask

	// Every pattern byte in use must be written before a scan can compare it.
	task automatic ensure_pattern(input bit fresh);
		for (int i = 0; i < eff_len; i++)
			if (fresh || !loaded[i])
				send_beat(ACT_LOAD, 7'(i), pick_symbol());
	endtask

	// Mostly scan bytes, with whole or broken copies of the pattern spliced in,
	// and now and then a load, a restart or an unused action.
	task automatic stream_item();
		int         r;
		logic [7:0] b;
		r = $urandom_range(0, 99);
		if (size_now != 32'd0 && fill >= size_now && $urandom_range(0, 3) == 0)
			r = 0;
		if (r < 3) begin
			send_beat(ACT_RESTART, 7'($urandom), 8'($urandom));
		end else if (r < 6) begin
			send_beat(ACT_UNUSED, 7'($urandom), 8'($urandom));
		end else if (r < 9) begin
			send_beat(ACT_LOAD, 7'($urandom), pick_symbol());
		end else begin
			if (insert_at < 0 && $urandom_range(0, 5) == 0) begin
				insert_at = 0;
				break_at = ($urandom_range(0, 3) == 0) ? $urandom_range(0, eff_len - 1) : -1;
			end
			if (insert_at >= 0) begin
				b = pat_shadow[insert_at];
				if (insert_at == break_at)
					b = ~b;
				insert_at = (insert_at + 1 == eff_len) ? -1 : insert_at + 1;
			end else if (r < 15) begin
				b = 8'($urandom);
			end else begin
				b = pick_symbol();
			end
			send_beat(ACT_SCAN, 7'($urandom), b);
		end
	endtask

	initial begin
		int          phase;
		int          count;
		bit          restart_first;
		bit          fresh;
		logic [7:0]  len_v;
		logic [11:0] win_v;
		logic [63:0] base_v;
		logic [31:0] size_v;

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Pattern 00 FF 00 near the top of the address space so that a later
		// hit wraps, with the widest window clamped to a nine-byte region.
		send_beat(ACT_LOAD, 7'd0, 8'h00);
		send_beat(ACT_LOAD, 7'd1, 8'hFF);
		send_beat(ACT_LOAD, 7'd2, 8'h00);
		send_beat(ACT_LOAD, 7'd127, 8'hA5);
		send_beat(ACT_SCAN, 7'h7F, 8'hFF);
		send_beat(ACT_UNUSED, 7'h7F, 8'hFF);
		configure(8'd3, 12'hFFF, 64'hFFFF_FFFF_FFFF_FFFE, 32'd9);
		// Overlapping copies are skipped, and the last beat falls past the region.
		repeat (5) begin
			send_beat(ACT_SCAN, 7'd0, 8'h00);
			send_beat(ACT_SCAN, 7'd0, 8'hFF);
		end
		send_beat(ACT_RESTART, 7'd0, 8'h00);
		send_beat(ACT_SCAN, 7'd0, 8'h00);
		send_beat(ACT_SCAN, 7'd0, 8'hFF);
		send_beat(ACT_SCAN, 7'd0, 8'h00);
		// A zero length acts as one, but the holdoff from the last hit runs out first.
		configure(8'd0, 12'hFFF, 64'hFFFF_FFFF_FFFF_FFFE, 32'd9);
		repeat (3) send_beat(ACT_SCAN, 7'd0, 8'h00);

		fed_items = 0;
		phase = 0;
		while (fed_items < ITEM_TARGET) begin
			sym_a = 8'($urandom);
			sym_b = 8'($urandom);
			restart_first = ($urandom_range(0, 3) != 0);
			fresh = $urandom_range(0, 1);
			count = $urandom_range(30, 60);
			if (phase == 2) begin
				configure(8'd128, 12'd0, 64'd0, 32'hFFFF_FFFF);
				restart_first = 1'b1;
				fresh = 1'b1;
				count = 150;
			end else if (phase == 3) begin
				// Lengths past the store act as the full store; the region carries on.
				configure(8'($urandom_range(129, 255)), 12'hFFF, '1, 32'hFFFF_FFFF);
				restart_first = 1'b0;
				fresh = 1'b0;
				count = 40;
			end else begin
				len_v = ($urandom_range(0, 5) == 0) ? 8'd0 : 8'($urandom_range(1, 6));
				case ($urandom_range(0, 3))
					0: win_v = 12'd0;
					1: win_v = 12'hFFF;
					default: win_v = 12'($urandom_range(1, 16));
				endcase
				case ($urandom_range(0, 2))
					0: base_v = 64'd0;
					1: base_v = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 50));
					default: base_v = {$urandom, $urandom};
				endcase
				case ($urandom_range(0, 9))
					0: size_v = 32'd0;
					1, 2: size_v = 32'hFFFF_FFFF;
					3, 4: size_v = 32'($urandom_range(41, 300));
					default: size_v = 32'($urandom_range(1, 40));
				endcase
				configure(len_v, win_v, base_v, size_v);
			end
			ensure_pattern(fresh);
			if (restart_first)
				send_beat(ACT_RESTART, 7'($urandom), 8'($urandom));
			repeat (count) begin
				if (fed_items >= CALM_FROM)
					calm = 1'b1;
				stream_item();
			end
			phase++;
		end

		settle();
		repeat (10) @(negedge clk);
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
